// ===== hdl/sn3d_pkg.sv =====
// Shared constants, tables, types and helpers of the 3D simplex noise block.
`default_nettype none

package sn3d_pkg;

   // Number formats.
   localparam int COORD_FRAC_BITS = 16;
   localparam int OUT_FRAC_BITS   = 15;
   localparam int OFF_W           = 22;
   localparam int CELL_W          = 8;

   // Lattice step and simplex denominator, both over the coordinate scale.
   localparam logic [OFF_W-1:0] UNIT  = OFF_W'(1 << COORD_FRAC_BITS);
   localparam logic [OFF_W-1:0] DENOM = OFF_W'(6 << COORD_FRAC_BITS);

   // Floor division by three of the skewed cell sum, done with a bias and a reciprocal.
   localparam logic [19:0] FLOOR3_BIAS_W = 20'd262146;
   localparam logic [18:0] FLOOR3_BIAS_Q = 19'd87382;
   localparam logic [19:0] RECIP3_CELL   = 20'd699051;
   localparam int          RECIP3_CELL_SH = 21;

   // Falloff: 0.5 - r^2 over D^2 is 18 * U^2.
   localparam logic signed [45:0] HALF_D2 = 46'sd77309411328;
   localparam logic [20:0] RECIP9 = 21'd1864136;
   localparam int          RECIP9_SH = 24;

   // Final scaling: floor(sum / (6 * 2^(COORD_FRAC_BITS + 25 - OUT_FRAC_BITS))).
   localparam int RES_SHIFT = COORD_FRAC_BITS + 26 - OUT_FRAC_BITS;
   localparam logic [23:0] FLOOR3_BIAS_R = 24'd4194306;
   localparam logic signed [23:0] FLOOR3_BIAS_RQ = 24'sd1398102;
   localparam logic [23:0] RECIP3_RES = 24'd11184811;
   localparam int          RECIP3_RES_SH = 25;

   // Output clamp.
   localparam logic signed [23:0] SAT_HI = 24'sd32767 < 24'((1 << OUT_FRAC_BITS) - 1)
                                           ? 24'sd32767 : 24'((1 << OUT_FRAC_BITS) - 1);
   localparam logic signed [23:0] SAT_LO = -24'sd32768 > -24'(1 << OUT_FRAC_BITS)
                                           ? -24'sd32768 : -24'(1 << OUT_FRAC_BITS);

   // Gradient codes.
   localparam logic [3:0] G_PX_PY = 4'd0;
   localparam logic [3:0] G_NX_PY = 4'd1;
   localparam logic [3:0] G_PX_NY = 4'd2;
   localparam logic [3:0] G_NX_NY = 4'd3;
   localparam logic [3:0] G_PX_PZ = 4'd4;
   localparam logic [3:0] G_NX_PZ = 4'd5;
   localparam logic [3:0] G_PX_NZ = 4'd6;
   localparam logic [3:0] G_NX_NZ = 4'd7;
   localparam logic [3:0] G_PY_PZ = 4'd8;
   localparam logic [3:0] G_NY_PZ = 4'd9;
   localparam logic [3:0] G_PY_NZ = 4'd10;
   localparam logic [3:0] G_NY_NZ = 4'd11;

   // Permutation table of the hash.
   localparam logic [7:0] PERM_ROM [256] = '{
      8'd151, 8'd160, 8'd137, 8'd91, 8'd90, 8'd15, 8'd131, 8'd13, 8'd201, 8'd95,
      8'd96, 8'd53, 8'd194, 8'd233, 8'd7, 8'd225, 8'd140, 8'd36, 8'd103, 8'd30,
      8'd69, 8'd142, 8'd8, 8'd99, 8'd37, 8'd240, 8'd21, 8'd10, 8'd23,
      8'd190, 8'd6, 8'd148, 8'd247, 8'd120, 8'd234, 8'd75, 8'd0, 8'd26, 8'd197,
      8'd62, 8'd94, 8'd252, 8'd219, 8'd203, 8'd117, 8'd35, 8'd11, 8'd32, 8'd57,
      8'd177, 8'd33,
      8'd88, 8'd237, 8'd149, 8'd56, 8'd87, 8'd174, 8'd20, 8'd125, 8'd136, 8'd171,
      8'd168, 8'd68, 8'd175, 8'd74, 8'd165, 8'd71, 8'd134, 8'd139, 8'd48, 8'd27,
      8'd166,
      8'd77, 8'd146, 8'd158, 8'd231, 8'd83, 8'd111, 8'd229, 8'd122, 8'd60, 8'd211,
      8'd133, 8'd230, 8'd220, 8'd105, 8'd92, 8'd41, 8'd55, 8'd46, 8'd245, 8'd40,
      8'd244,
      8'd102, 8'd143, 8'd54, 8'd65, 8'd25, 8'd63, 8'd161, 8'd1, 8'd216, 8'd80,
      8'd73, 8'd209, 8'd76, 8'd132, 8'd187, 8'd208, 8'd89, 8'd18, 8'd169, 8'd200,
      8'd196,
      8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86, 8'd164, 8'd100, 8'd109, 8'd198,
      8'd173, 8'd186, 8'd3, 8'd64, 8'd52, 8'd217, 8'd226, 8'd250, 8'd124, 8'd123,
      8'd5, 8'd202, 8'd38, 8'd147, 8'd118, 8'd126, 8'd255, 8'd82, 8'd85, 8'd212,
      8'd207, 8'd206, 8'd59, 8'd227, 8'd47, 8'd16, 8'd58, 8'd17, 8'd182, 8'd189,
      8'd28, 8'd42,
      8'd223, 8'd183, 8'd170, 8'd213, 8'd119, 8'd248, 8'd152, 8'd2, 8'd44, 8'd154,
      8'd163, 8'd70, 8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43, 8'd172, 8'd9,
      8'd129, 8'd22, 8'd39, 8'd253, 8'd19, 8'd98, 8'd108, 8'd110, 8'd79, 8'd113,
      8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104, 8'd218, 8'd246, 8'd97, 8'd228,
      8'd251, 8'd34, 8'd242, 8'd193, 8'd238, 8'd210, 8'd144, 8'd12, 8'd191, 8'd179,
      8'd162, 8'd241, 8'd81, 8'd51, 8'd145, 8'd235, 8'd249, 8'd14, 8'd239, 8'd107,
      8'd49, 8'd192, 8'd214, 8'd31, 8'd181, 8'd199, 8'd106, 8'd157, 8'd184, 8'd84,
      8'd204, 8'd176, 8'd115, 8'd121, 8'd50, 8'd45, 8'd127, 8'd4, 8'd150, 8'd254,
      8'd138, 8'd236, 8'd205, 8'd93, 8'd222, 8'd114, 8'd67, 8'd29, 8'd24, 8'd72,
      8'd243, 8'd141, 8'd128, 8'd195, 8'd78, 8'd66, 8'd215, 8'd61, 8'd156, 8'd180
   };

   // One classified point: offsets from the base corner, cell and tetrahedron order.
   typedef struct packed {
      logic signed [OFF_W-1:0] x0;
      logic signed [OFF_W-1:0] y0;
      logic signed [OFF_W-1:0] z0;
      logic [CELL_W-1:0]       ii;
      logic [CELL_W-1:0]       jj;
      logic [CELL_W-1:0]       kk;
      logic                    i1;
      logic                    j1;
      logic                    k1;
      logic                    i2;
      logic                    j2;
      logic                    k2;
   } sn3d_item_type;

   // Hash value modulo 12, by reciprocal multiply.
   function automatic logic [3:0] mod12(input logic [7:0] h);
      logic [15:0] p;
      logic [7:0]  r;
      p = 16'(h) * 16'd171;
      r = h - 8'(8'(p[15:11]) * 8'd12);
      return r[3:0];
   endfunction

endpackage

`default_nettype wire

// ===== hdl/sn3d_front.sv =====
// Front end: skews the point, finds the cell and orders the tetrahedron.
`default_nettype none

module sn3d_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic signed [31:0]    req_coord_x,
   input  wire logic signed [31:0]    req_coord_y,
   input  wire logic signed [31:0]    req_coord_z,
   input  wire logic                  q_full,
   output logic                       push_valid,
   output sn3d_pkg::sn3d_item_type    push_item
);
   import sn3d_pkg::*;

   logic advance;
   logic v1_ff, v2_ff, v3_ff;
   logic signed [34:0] s_i, s_j, s_k;
   logic [19:0] w_i_in, w_j_in, w_k_in;
   logic [19:0] w_i_ff, w_j_ff, w_k_ff;
   logic [OFF_W-1:0] x1_ff, y1_ff, z1_ff, x2_ff, y2_ff, z2_ff;
   logic [39:0] p_i, p_j, p_k;
   logic [CELL_W-1:0] ci_in, cj_in, ck_in, ci_ff, cj_ff, ck_ff, ci3_ff, cj3_ff, ck3_ff;
   logic [5:0] csum;
   logic [OFF_W-1:0] x0_in, y0_in, z0_in;
   logic signed [OFF_W-1:0] x0_ff, y0_ff, z0_ff;

   // The whole front moves unless its last item cannot enter the queue.
   assign advance    = !(v3_ff && q_full);
   assign req_stall  = !advance;
   assign push_valid = v3_ff && advance;

   // Skewed cell sums, scaled down and biased for an unsigned divide by three.
   always_comb begin
      s_i = (35'(req_coord_x) <<< 2) + 35'(req_coord_y) + 35'(req_coord_z);
      s_j = 35'(req_coord_x) + (35'(req_coord_y) <<< 2) + 35'(req_coord_z);
      s_k = 35'(req_coord_x) + 35'(req_coord_y) + (35'(req_coord_z) <<< 2);
      w_i_in = 20'($signed(s_i[34:COORD_FRAC_BITS])) + FLOOR3_BIAS_W;
      w_j_in = 20'($signed(s_j[34:COORD_FRAC_BITS])) + FLOOR3_BIAS_W;
      w_k_in = 20'($signed(s_k[34:COORD_FRAC_BITS])) + FLOOR3_BIAS_W;
   end

   // Divide by three and remove the bias; only the low cell bits are kept.
   always_comb begin
      p_i = 40'(w_i_ff) * 40'(RECIP3_CELL);
      p_j = 40'(w_j_ff) * 40'(RECIP3_CELL);
      p_k = 40'(w_k_ff) * 40'(RECIP3_CELL);
      ci_in = 8'(p_i[39:RECIP3_CELL_SH]) - 8'(FLOOR3_BIAS_Q);
      cj_in = 8'(p_j[39:RECIP3_CELL_SH]) - 8'(FLOOR3_BIAS_Q);
      ck_in = 8'(p_k[39:RECIP3_CELL_SH]) - 8'(FLOOR3_BIAS_Q);
   end

   // Offsets from the base corner over D; the true values fit the offset width.
   always_comb begin
      csum  = 6'(ci_ff) + 6'(cj_ff) + 6'(ck_ff);
      x0_in = 22'(x2_ff * 22'd6) - (22'(6'(6'(ci_ff) * 6'd6)) << COORD_FRAC_BITS)
              + (22'(csum) << COORD_FRAC_BITS);
      y0_in = 22'(y2_ff * 22'd6) - (22'(6'(6'(cj_ff) * 6'd6)) << COORD_FRAC_BITS)
              + (22'(csum) << COORD_FRAC_BITS);
      z0_in = 22'(z2_ff * 22'd6) - (22'(6'(6'(ck_ff) * 6'd6)) << COORD_FRAC_BITS)
              + (22'(csum) << COORD_FRAC_BITS);
   end

   // Pipeline registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      if (advance) begin
         w_i_ff <= w_i_in;
         w_j_ff <= w_j_in;
         w_k_ff <= w_k_in;
         x1_ff  <= req_coord_x[OFF_W-1:0];
         y1_ff  <= req_coord_y[OFF_W-1:0];
         z1_ff  <= req_coord_z[OFF_W-1:0];
         ci_ff  <= ci_in;
         cj_ff  <= cj_in;
         ck_ff  <= ck_in;
         x2_ff  <= x1_ff;
         y2_ff  <= y1_ff;
         z2_ff  <= z1_ff;
         x0_ff  <= $signed(x0_in);
         y0_ff  <= $signed(y0_in);
         z0_ff  <= $signed(z0_in);
         ci3_ff <= ci_ff;
         cj3_ff <= cj_ff;
         ck3_ff <= ck_ff;
      end
   end

   // Tetrahedron order from the offset ranking.
   always_comb begin
      push_item    = '0;
      push_item.x0 = x0_ff;
      push_item.y0 = y0_ff;
      push_item.z0 = z0_ff;
      push_item.ii = ci3_ff;
      push_item.jj = cj3_ff;
      push_item.kk = ck3_ff;
      if (x0_ff >= y0_ff) begin
         if (y0_ff >= z0_ff) begin
            {push_item.i1, push_item.j1, push_item.k1} = 3'b100;
            {push_item.i2, push_item.j2, push_item.k2} = 3'b110;
         end else if (x0_ff >= z0_ff) begin
            {push_item.i1, push_item.j1, push_item.k1} = 3'b100;
            {push_item.i2, push_item.j2, push_item.k2} = 3'b101;
         end else begin
            {push_item.i1, push_item.j1, push_item.k1} = 3'b001;
            {push_item.i2, push_item.j2, push_item.k2} = 3'b101;
         end
      end else begin
         if (y0_ff < z0_ff) begin
            {push_item.i1, push_item.j1, push_item.k1} = 3'b001;
            {push_item.i2, push_item.j2, push_item.k2} = 3'b011;
         end else if (x0_ff < z0_ff) begin
            {push_item.i1, push_item.j1, push_item.k1} = 3'b010;
            {push_item.i2, push_item.j2, push_item.k2} = 3'b011;
         end else begin
            {push_item.i1, push_item.j1, push_item.k1} = 3'b010;
            {push_item.i2, push_item.j2, push_item.k2} = 3'b110;
         end
      end
   end

endmodule

`default_nettype wire

// ===== hdl/sn3d_queue.sv =====
// Four-entry queue of classified items between the front and back ends.
`default_nettype none

module sn3d_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push_valid,
   input  wire sn3d_pkg::sn3d_item_type  push_item,
   output logic                          q_full,
   input  wire logic                     pop,
   output logic                          q_empty,
   output sn3d_pkg::sn3d_item_type       pop_item
);
   import sn3d_pkg::*;

   sn3d_item_type entry_ff [4];
   logic [1:0] wr_ptr_ff, rd_ptr_ff;
   logic [2:0] count_ff;
   logic       do_pop;

   assign q_full   = (count_ff == 3'd4);
   assign q_empty  = (count_ff == 3'd0);
   assign do_pop   = pop && !q_empty;
   assign pop_item = entry_ff[rd_ptr_ff];

   // Storage.
   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         if (push_valid) begin
            wr_ptr_ff <= wr_ptr_ff + 2'd1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 2'd1;
         end
         count_ff <= count_ff + 3'(push_valid) - 3'(do_pop);
      end
   end

endmodule

`default_nettype wire

// ===== hdl/sn3d_back.sv =====
// Back end: hashes the four corners, evaluates falloff and gradients, sums and scales.
`default_nettype none

module sn3d_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     q_empty,
   input  wire sn3d_pkg::sn3d_item_type  pop_item,
   output logic                          pop,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic signed [15:0]            rsp_noise_value
);
   import sn3d_pkg::*;

   logic advance;
   logic [10:0] v_ff;

   logic signed [OFF_W-1:0] off_in [4][3];
   logic signed [OFF_W-1:0] off1_ff [4][3], off2_ff [4][3], off3_ff [4][3];
   logic [7:0] io [4], jo [4], ko [4];
   logic [7:0] hk_in [4], hk1_ff [4], ia1_ff [4], ja1_ff [4];
   logic [7:0] hj_in [4], hj2_ff [4], ia2_ff [4];
   logic [7:0] hi_in [4], hi3_ff [4];
   logic signed [43:0] sq_in [4][3], sq2_ff [4][3];
   logic signed [45:0] tn_in [4], tn3_ff [4];
   logic [3:0]  g [4];
   logic signed [22:0] dot_in [4], dot4_ff [4], dot5_ff [4], dot6_ff [4], dot7_ff [4];
   logic [32:0] vt [4];
   logic [37:0] ph [4];
   logic [13:0] qh_in [4], qh4_ff [4];
   logic [16:0] rh [4];
   logic [19:0] wl_in [4], wl4_ff [4];
   logic        neg4_ff [4];
   logic [40:0] pl [4];
   logic [29:0] tq_in [4], tq5_ff [4];
   logic [59:0] t2p [4];
   logic [28:0] t2_ff [4];
   logic [57:0] t4p [4];
   logic [26:0] t4_ff [4];
   logic signed [49:0] prod_in [4], prod8_ff [4];
   logic signed [51:0] total;
   logic [23:0] wr_in, wr9_ff;
   logic [47:0] pr;
   logic signed [23:0] res_in, res10_ff;
   logic signed [15:0] noise_ff;

   // Everything moves together unless a finished result is held.
   assign advance         = !(v_ff[10] && rsp_stall);
   assign pop             = advance && !q_empty;
   assign rsp_valid       = v_ff[10];
   assign rsp_noise_value = noise_ff;

   // Corner steps of the tetrahedron.
   always_comb begin
      io[0] = 8'd0;               jo[0] = 8'd0;               ko[0] = 8'd0;
      io[1] = 8'(pop_item.i1);    jo[1] = 8'(pop_item.j1);    ko[1] = 8'(pop_item.k1);
      io[2] = 8'(pop_item.i2);    jo[2] = 8'(pop_item.j2);    ko[2] = 8'(pop_item.k2);
      io[3] = 8'd1;               jo[3] = 8'd1;               ko[3] = 8'd1;
   end

   // Corner offsets and the first hash level.
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         off_in[c][0] = pop_item.x0 - (io[c][0] ? $signed(DENOM) : '0) + $signed(OFF_W'(c) * UNIT);
         off_in[c][1] = pop_item.y0 - (jo[c][0] ? $signed(DENOM) : '0) + $signed(OFF_W'(c) * UNIT);
         off_in[c][2] = pop_item.z0 - (ko[c][0] ? $signed(DENOM) : '0) + $signed(OFF_W'(c) * UNIT);
         hk_in[c] = PERM_ROM[pop_item.kk + ko[c]];
      end
   end

   // Squares and the second hash level.
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         for (int a = 0; a < 3; a++) begin
            sq_in[c][a] = 44'(off1_ff[c][a]) * 44'(off1_ff[c][a]);
         end
         hj_in[c] = PERM_ROM[ja1_ff[c] + hk1_ff[c]];
      end
   end

   // Falloff numerator and the third hash level.
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         tn_in[c] = HALF_D2 - (46'(sq2_ff[c][0]) + 46'(sq2_ff[c][1]) + 46'(sq2_ff[c][2]));
         hi_in[c] = PERM_ROM[ia2_ff[c] + hj2_ff[c]];
      end
   end

   // Gradient dot product and the upper half of the divide by 144.
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         g[c] = mod12(hi3_ff[c]);
         unique case (g[c])
            G_PX_PY: dot_in[c] =  23'(off3_ff[c][0]) + 23'(off3_ff[c][1]);
            G_NX_PY: dot_in[c] = -23'(off3_ff[c][0]) + 23'(off3_ff[c][1]);
            G_PX_NY: dot_in[c] =  23'(off3_ff[c][0]) - 23'(off3_ff[c][1]);
            G_NX_NY: dot_in[c] = -23'(off3_ff[c][0]) - 23'(off3_ff[c][1]);
            G_PX_PZ: dot_in[c] =  23'(off3_ff[c][0]) + 23'(off3_ff[c][2]);
            G_NX_PZ: dot_in[c] = -23'(off3_ff[c][0]) + 23'(off3_ff[c][2]);
            G_PX_NZ: dot_in[c] =  23'(off3_ff[c][0]) - 23'(off3_ff[c][2]);
            G_NX_NZ: dot_in[c] = -23'(off3_ff[c][0]) - 23'(off3_ff[c][2]);
            G_PY_PZ: dot_in[c] =  23'(off3_ff[c][1]) + 23'(off3_ff[c][2]);
            G_NY_PZ: dot_in[c] = -23'(off3_ff[c][1]) + 23'(off3_ff[c][2]);
            G_PY_NZ: dot_in[c] =  23'(off3_ff[c][1]) - 23'(off3_ff[c][2]);
            G_NY_NZ: dot_in[c] = -23'(off3_ff[c][1]) - 23'(off3_ff[c][2]);
            default: dot_in[c] = '0;
         endcase
         vt[c]    = tn3_ff[c][36:4];
         ph[c]    = 38'(vt[c][32:16]) * 38'(RECIP9);
         qh_in[c] = ph[c][37:RECIP9_SH];
         rh[c]    = vt[c][32:16] - 17'(17'(qh_in[c]) * 17'd9);
         wl_in[c] = {rh[c][3:0], vt[c][15:0]};
      end
   end

   // Lower half of the divide; negative falloff gives no contribution.
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         pl[c]    = 41'(wl4_ff[c]) * 41'(RECIP9);
         tq_in[c] = neg4_ff[c] ? '0 : {qh4_ff[c], pl[c][39:RECIP9_SH]};
      end
   end

   // Fourth power of the falloff and the weighted gradient.
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         t2p[c]     = 60'(tq5_ff[c]) * 60'(tq5_ff[c]);
         t4p[c]     = 58'(t2_ff[c]) * 58'(t2_ff[c]);
         prod_in[c] = 50'($signed({1'b0, t4_ff[c]})) * 50'(dot7_ff[c]);
      end
   end

   // Sum of the corners, scaled down and biased for the final divide by three.
   always_comb begin
      total = 52'(prod8_ff[0]) + 52'(prod8_ff[1]) + 52'(prod8_ff[2]) + 52'(prod8_ff[3]);
      wr_in = 24'($signed(total[51:RES_SHIFT])) + FLOOR3_BIAS_R;
   end

   // Divide by three and remove the bias.
   always_comb begin
      pr     = 48'(wr9_ff) * 48'(RECIP3_RES);
      res_in = $signed(24'(pr[47:RECIP3_RES_SH])) - FLOOR3_BIAS_RQ;
   end

   // Valid chain.
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (advance) begin
         v_ff <= {v_ff[9:0], !q_empty};
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int c = 0; c < 4; c++) begin
            off1_ff[c] <= off_in[c];
            off2_ff[c] <= off1_ff[c];
            off3_ff[c] <= off2_ff[c];
            hk1_ff[c]  <= hk_in[c];
            ia1_ff[c]  <= pop_item.ii + io[c];
            ja1_ff[c]  <= pop_item.jj + jo[c];
            sq2_ff[c]  <= sq_in[c];
            hj2_ff[c]  <= hj_in[c];
            ia2_ff[c]  <= ia1_ff[c];
            tn3_ff[c]  <= tn_in[c];
            hi3_ff[c]  <= hi_in[c];
            dot4_ff[c] <= dot_in[c];
            qh4_ff[c]  <= qh_in[c];
            wl4_ff[c]  <= wl_in[c];
            neg4_ff[c] <= tn3_ff[c][45];
            tq5_ff[c]  <= tq_in[c];
            dot5_ff[c] <= dot4_ff[c];
            t2_ff[c]   <= t2p[c][58:30];
            dot6_ff[c] <= dot5_ff[c];
            t4_ff[c]   <= t4p[c][56:30];
            dot7_ff[c] <= dot6_ff[c];
            prod8_ff[c] <= prod_in[c];
         end
         wr9_ff   <= wr_in;
         res10_ff <= res_in;
         if (res10_ff > SAT_HI) begin
            noise_ff <= 16'(SAT_HI);
         end else if (res10_ff < SAT_LO) begin
            noise_ff <= 16'(SAT_LO);
         end else begin
            noise_ff <= 16'(res10_ff);
         end
      end
   end

endmodule

`default_nettype wire

// ===== hdl/simplex_noise_3d.sv =====
// Top level of the 3D simplex noise block.
`default_nettype none

// 3D simplex gradient noise. Each item carries a point in signed Q16.16 and
// yields one Q1.15 noise value, saturated to [-1, 1). The block takes one item
// per clock cycle while req_stall is low. A point passes three front stages
// (skew, cell divide, corner offsets), waits in a four-entry queue, and then
// passes eleven back stages (three hash levels through the permutation ROM,
// falloff squares, a two-step divide by 144, two squarings, the gradient
// multiply, the corner sum and the final divide with saturation). A held
// result stops the back end; the queue then absorbs up to four items before
// req_stall rises.
module simplex_noise_3d (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [31:0] req_coord_x,
   input  wire logic signed [31:0] req_coord_y,
   input  wire logic signed [31:0] req_coord_z,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [15:0]      rsp_noise_value
);
   import sn3d_pkg::*;

   logic          q_full, q_empty, push_valid, pop;
   sn3d_item_type push_item, pop_item;

   // Classification of incoming points.
   sn3d_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_coord_x (req_coord_x),
      .req_coord_y (req_coord_y),
      .req_coord_z (req_coord_z),
      .q_full      (q_full),
      .push_valid  (push_valid),
      .push_item   (push_item)
   );

   // Decoupling queue.
   sn3d_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .q_full     (q_full),
      .pop        (pop),
      .q_empty    (q_empty),
      .pop_item   (pop_item)
   );

   // Noise evaluation.
   sn3d_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .pop_item        (pop_item),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_noise_value (rsp_noise_value)
   );

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench of the 3D simplex noise block.
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sn3d_pkg::*;

   localparam int RANDOM_POINTS = 1400;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int DRAIN_CYCLES  = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [31:0] req_coord_x = '0;
   logic signed [31:0] req_coord_y = '0;
   logic signed [31:0] req_coord_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_noise_value;

   // One row of the directed table; check_now marks a value typed in by hand.
   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      bit                 check_now;
      logic signed [15:0] noise;
   } point_row_type;

   logic signed [15:0] noise_due [$];
   int mismatches = 0;
   int cycles = 0;

   simplex_noise_3d DUT (.*);

   // Clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Gradient directions, indexed by hash mod 12.
   function automatic int grad_comp(input int g, input int axis);
      int tab [12][3];
      tab = '{'{1,1,0}, '{-1,1,0}, '{1,-1,0}, '{-1,-1,0}, '{1,0,1}, '{-1,0,1},
              '{1,0,-1}, '{-1,0,-1}, '{0,1,1}, '{0,-1,1}, '{0,1,-1}, '{0,-1,-1}};
      return tab[g][axis];
   endfunction

   function automatic longint floor_div(input longint a, input longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0) q = q - 1;
      return q;
   endfunction

   function automatic int lattice_hash(input int a, input int b, input int c);
      int h;
      h = PERM_ROM[c & 255];
      h = PERM_ROM[(b + h) & 255];
      h = PERM_ROM[(a + h) & 255];
      return h % 12;
   endfunction

   // Falloff-weighted gradient contribution of one corner, over D.
   function automatic longint corner_weight(input longint xn, input longint yn,
                                            input longint zn, input int g);
      longint u, tn, dot;
      longint unsigned tq, t2, t4;
      u = longint'(1) << COORD_FRAC_BITS;
      tn = 18 * u * u - (xn * xn + yn * yn + zn * zn);
      if (tn < 0) return 0;
      tq = (longint'(tn) >>> (2 * COORD_FRAC_BITS - 30)) / 36;
      t2 = (tq * tq) >> 30;
      t4 = (t2 * t2) >> 30;
      dot = grad_comp(g, 0) * xn + grad_comp(g, 1) * yn + grad_comp(g, 2) * zn;
      return longint'(t4) * dot;
   endfunction

   // Expected noise value of one point.
   function automatic logic signed [15:0] simplex_noise(input logic signed [31:0] px,
                                                        input logic signed [31:0] py,
                                                        input logic signed [31:0] pz);
      longint u, d, x, y, z, ci, cj, ck, ts, x0, y0, z0, acc, res;
      int i1, j1, k1, i2, j2, k2, ii, jj, kk;
      u = longint'(1) << COORD_FRAC_BITS;
      d = 6 * u;
      x = px; y = py; z = pz;
      ci = floor_div(4 * x + y + z, 3 * u);
      cj = floor_div(x + 4 * y + z, 3 * u);
      ck = floor_div(x + y + 4 * z, 3 * u);
      ts = (ci + cj + ck) * u;
      x0 = 6 * x - 6 * ci * u + ts;
      y0 = 6 * y - 6 * cj * u + ts;
      z0 = 6 * z - 6 * ck * u + ts;
      // Tetrahedron order from the ranking of the offsets.
      if (x0 >= y0) begin
         if (y0 >= z0) begin i1 = 1; j1 = 0; k1 = 0; i2 = 1; j2 = 1; k2 = 0; end
         else if (x0 >= z0) begin i1 = 1; j1 = 0; k1 = 0; i2 = 1; j2 = 0; k2 = 1; end
         else begin i1 = 0; j1 = 0; k1 = 1; i2 = 1; j2 = 0; k2 = 1; end
      end else begin
         if (y0 < z0) begin i1 = 0; j1 = 0; k1 = 1; i2 = 0; j2 = 1; k2 = 1; end
         else if (x0 < z0) begin i1 = 0; j1 = 1; k1 = 0; i2 = 0; j2 = 1; k2 = 1; end
         else begin i1 = 0; j1 = 1; k1 = 0; i2 = 1; j2 = 1; k2 = 0; end
      end
      ii = int'(ci & 255); jj = int'(cj & 255); kk = int'(ck & 255);
      acc = corner_weight(x0, y0, z0, lattice_hash(ii, jj, kk));
      acc += corner_weight(x0 - i1 * d + u, y0 - j1 * d + u, z0 - k1 * d + u,
                           lattice_hash(ii + i1, jj + j1, kk + k1));
      acc += corner_weight(x0 - i2 * d + 2 * u, y0 - j2 * d + 2 * u, z0 - k2 * d + 2 * u,
                           lattice_hash(ii + i2, jj + j2, kk + k2));
      acc += corner_weight(x0 - d + 3 * u, y0 - d + 3 * u, z0 - d + 3 * u,
                           lattice_hash(ii + 1, jj + 1, kk + 1));
      res = floor_div(acc, longint'(6) << (COORD_FRAC_BITS + 25 - OUT_FRAC_BITS));
      // Saturate to [-1, 1).
      if (res > 32767) res = 32767;
      if (res < -32768) res = -32768;
      return 16'(res);
   endfunction

   // Present one point and wait until it is taken.
   task automatic send_point(input logic signed [31:0] x, input logic signed [31:0] y,
                             input logic signed [31:0] z, input bit check_now,
                             input logic signed [15:0] noise);
      logic signed [15:0] model;
      model = simplex_noise(x, y, z);
      if (check_now && model !== noise) begin
         mismatches++;
         if (mismatches <= 10)
            $display("table row (%0d,%0d,%0d): typed %0d, predicted %0d",
                     x, y, z, noise, model);
      end
      req_valid <= 1'b1;
      req_coord_x <= x;
      req_coord_y <= y;
      req_coord_z <= z;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      noise_due.push_back(model);
      @(negedge clock);
   endtask

   // Random gap between bursts.
   task automatic idle_gap();
      int n;
      n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   // Mostly moderate coordinates, sometimes any 32-bit pattern.
   function automatic logic signed [31:0] rand_coord();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
         default: return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
      endcase
   endfunction

   // Results are compared against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (noise_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected noise item %0d", rsp_noise_value);
         end else begin
            logic signed [15:0] want;
            want = noise_due.pop_front();
            if (rsp_noise_value !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("noise_value: expected %0d, got %0d", want, rsp_noise_value);
            end
         end
      end
   end

   // Receiver stalls on its own pattern with calm stretches.
   always @(negedge clock) begin
      if (reset || cycles % 600 < 150) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(0, 2) == 0);
   end

   // Cycle limit.
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   point_row_type rows [$];

   initial begin
      // Zero point is a lattice corner: the base corner has a zero offset and
      // every other corner lies outside the falloff radius.
      rows.push_back('{32'sd0, 32'sd0, 32'sd0, 1'b1, 16'sd0});
      rows.push_back('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, 16'sd0});
      rows.push_back('{-32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000, 1'b0, 16'sd0});
      rows.push_back('{32'sh7FFF_FFFF, -32'sh8000_0000, 32'sd0, 1'b0, 16'sd0});
      rows.push_back('{-32'sh8000_0000, 32'sh7FFF_FFFF, -32'sd1, 1'b0, 16'sd0});
      rows.push_back('{32'sd1, -32'sd1, 32'sd1, 1'b0, 16'sd0});
      rows.push_back('{32'sh0000_8000, 32'sh0000_4000, 32'sh0000_2000, 1'b0, 16'sd0});
      rows.push_back('{32'sh0000_2000, 32'sh0000_8000, 32'sh0000_4000, 1'b0, 16'sd0});
      rows.push_back('{32'sh0000_4000, 32'sh0000_2000, 32'sh0000_8000, 1'b0, 16'sd0});
      rows.push_back('{32'sh0000_2000, 32'sh0000_4000, 32'sh0000_8000, 1'b0, 16'sd0});
      rows.push_back('{32'sh0000_8000, 32'sh0000_2000, 32'sh0000_4000, 1'b0, 16'sd0});
      rows.push_back('{32'sh0000_4000, 32'sh0000_8000, 32'sh0000_2000, 1'b0, 16'sd0});
      // Points 256 apart on each axis lie in cells 512 apart and repeat the pattern.
      rows.push_back('{32'sh0001_3456, 32'sh0002_789A, 32'sh0003_BCDE, 1'b0, 16'sd0});
      rows.push_back('{32'sh0101_3456, 32'sh0102_789A, 32'sh0103_BCDE, 1'b0, 16'sd0});
      rows.push_back('{-32'sh0000_5555, 32'sh0000_AAAA, -32'sh0001_2345, 1'b0, 16'sd0});
      rows.push_back('{32'sh5555_5555, -32'sh2AAA_AAAB, 32'sh0F0F_0F0F, 1'b0, 16'sd0});

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[r]) begin
         send_point(rows[r].x, rows[r].y, rows[r].z, rows[r].check_now, rows[r].noise);
         idle_gap();
      end
      repeat (RANDOM_POINTS) begin
         send_point(rand_coord(), rand_coord(), rand_coord(), 1'b0, 16'sd0);
         idle_gap();
      end
      req_valid <= 1'b0;

      while (noise_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && noise_due.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
hdl/sn3d_pkg.sv
hdl/sn3d_front.sv
hdl/sn3d_queue.sv
hdl/sn3d_back.sv
hdl/simplex_noise_3d.sv
sim/tb.sv
